// ===== hdl/drre_pkg.sv =====
// Shared types, constants and helpers of the dirty-cell run rectangle emitter.
package drre_pkg;

  // Default geometry
  localparam int GRID_WIDTH_DEF  = 32;
  localparam int GRID_HEIGHT_DEF = 24;
  localparam int STORE_BYTES_DEF = 384;

  // Grid coordinates are carried at their widest legal size
  localparam int COL_MAX_W = 5;
  localparam int ROW_MAX_W = 5;

  // Result queue depth and the width of its occupancy count
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // Configuration register width and index codes
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BACKGROUND_COLOUR = 3'd0,
    REG_FULL_REPAINT      = 3'd1,
    REG_CELL_SIZE         = 3'd2,
    REG_INK_CODE          = 3'd3,
    REG_LIT_CODE          = 3'd4,
    REG_INK_COLOUR        = 3'd5,
    REG_LIT_COLOUR        = 3'd6
  } reg_idx_e;

  // Input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [8:0] byte_address;
    logic [7:0] byte_value;
    logic       frame_select;
  } in_word_t;

  typedef struct packed {
    logic [8:0]  rect_x;
    logic [8:0]  rect_y;
    logic [9:0]  rect_width;
    logic [4:0]  rect_height;
    logic [15:0] fill_colour;
    logic        last_of_item;
  } out_word_t;

  typedef struct packed {
    logic [15:0] background_colour;
    logic        full_repaint;
    logic [4:0]  cell_size;
    logic [1:0]  ink_code;
    logic [1:0]  lit_code;
    logic [15:0] ink_colour;
    logic [15:0] lit_colour;
  } cfg_t;

  // One scan in flight between the memory read and the run logic
  typedef struct packed {
    logic                 valid;
    logic [COL_MAX_W-1:0] col;
    logic [ROW_MAX_W-1:0] row;
    logic [1:0]           lane;
    logic                 a_ok;
    logic                 b_ok;
    logic                 last_col;
  } scan_job_t;

  // Rectangles handed from the run logic to the result queue
  typedef struct packed {
    logic      push_one;
    logic      push_two;
    out_word_t word0;
    out_word_t word1;
  } rect_push_t;

  // Pick one 2-bit cell, first cell in the top bits
  function automatic logic [1:0] cell_code(input logic [7:0] byte_val, input logic [1:0] lane);
    logic [1:0] code;
    case (lane)
      2'd0:    code = byte_val[7:6];
      2'd1:    code = byte_val[5:4];
      2'd2:    code = byte_val[3:2];
      default: code = byte_val[1:0];
    endcase
    return code;
  endfunction

  // Clamp the cell edge to 1..16
  function automatic logic [4:0] cell_edge(input logic [4:0] cs);
    logic [4:0] e;
    if (cs == 5'd0) begin
      e = 5'd1;
    end else if (cs > 5'd16) begin
      e = 5'd16;
    end else begin
      e = cs;
    end
    return e;
  endfunction

endpackage

// ===== hdl/drre_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
module drre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write, then register both reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hdl/drre_run.sv =====
// Run tracker: classifies the scanned cell, merges runs and builds rectangles.
module drre_run #(
  parameter int GRID_WIDTH = drre_pkg::GRID_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  drre_pkg::scan_job_t    job_i,
  input  logic [7:0]             rdata_a_i,
  input  logic [7:0]             rdata_b_i,
  input  drre_pkg::cfg_t         cfg_i,
  output drre_pkg::rect_push_t   push_o
);

  localparam int CW = drre_pkg::COL_MAX_W;
  localparam int RW = drre_pkg::ROW_MAX_W;
  localparam logic [CW:0] END_COL = (CW + 1)'(GRID_WIDTH);

  logic          run_open_q, run_open_d;
  logic [CW-1:0] run_first_q, run_first_d;
  logic [15:0]   run_colour_q, run_colour_d;

  logic [4:0]    e;
  logic [1:0]    code, other;
  logic          want, close1, keep, open_mid, close2;
  logic [15:0]   colour, colour_mid;
  logic [CW-1:0] first_mid;
  drre_pkg::out_word_t rect_a, rect_b;

  // Scale one run into a pixel rectangle
  function automatic drre_pkg::out_word_t make_rect(
    input logic [CW-1:0] first,
    input logic [CW:0]   endc,
    input logic [RW-1:0] row,
    input logic [4:0]    edge_len,
    input logic [15:0]   fill
  );
    drre_pkg::out_word_t r;
    logic [CW:0]    len;
    logic [CW+5:0]  px, py, pw;
    len = endc - {1'b0, first};
    px  = (CW + 6)'(first) * (CW + 6)'(edge_len);
    py  = (CW + 6)'(row) * (CW + 6)'(edge_len);
    pw  = (CW + 6)'(len) * (CW + 6)'(edge_len);
    r.rect_x       = px[8:0];
    r.rect_y       = py[8:0];
    r.rect_width   = pw[9:0];
    r.rect_height  = edge_len;
    r.fill_colour  = fill;
    r.last_of_item = 1'b1;
    return r;
  endfunction

  // Classify the cell and decide which runs close
  always_comb begin
    e      = drre_pkg::cell_edge(cfg_i.cell_size);
    code   = job_i.a_ok ? drre_pkg::cell_code(rdata_a_i, job_i.lane) : 2'd0;
    other  = job_i.b_ok ? drre_pkg::cell_code(rdata_b_i, job_i.lane) : 2'd0;
    want   = cfg_i.full_repaint || (code != other);
    if (code == cfg_i.ink_code) begin
      colour = cfg_i.ink_colour;
    end else if (code == cfg_i.lit_code) begin
      colour = cfg_i.lit_colour;
    end else begin
      colour = cfg_i.background_colour;
    end

    close1     = run_open_q && (!want || (colour != run_colour_q));
    keep       = run_open_q && !close1;
    open_mid   = keep || want;
    first_mid  = keep ? run_first_q : job_i.col;
    colour_mid = keep ? run_colour_q : colour;
    close2     = job_i.last_col && open_mid;

    rect_a = make_rect(run_first_q, {1'b0, job_i.col}, job_i.row, e, run_colour_q);
    rect_b = make_rect(first_mid, END_COL, job_i.row, e, colour_mid);

    // Order: interrupted run first, then the run closed by the row end
    push_o.push_two = job_i.valid && close1 && close2;
    push_o.push_one = job_i.valid && (close1 ^ close2);
    push_o.word0    = close1 ? rect_a : rect_b;
    push_o.word0.last_of_item = !(close1 && close2);
    push_o.word1    = rect_b;

    run_open_d   = run_open_q;
    run_first_d  = run_first_q;
    run_colour_d = run_colour_q;
    if (job_i.valid) begin
      run_open_d   = open_mid && !job_i.last_col;
      run_first_d  = first_mid;
      run_colour_d = colour_mid;
    end
  end

  // Hold the open run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q   <= 1'b0;
      run_first_q  <= '0;
      run_colour_q <= '0;
    end else begin
      run_open_q   <= run_open_d;
      run_first_q  <= run_first_d;
      run_colour_q <= run_colour_d;
    end
  end

endmodule

// ===== hdl/drre_outq.sv =====
// Result queue: takes up to two rectangles a cycle, releases one word a cycle while out_ready_i is high.
module drre_outq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  drre_pkg::rect_push_t                push_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output drre_pkg::out_word_t                 out_word_o,
  output logic [drre_pkg::OUTQ_CNT_W-1:0]     count_o
);

  localparam int PW = $clog2(drre_pkg::OUTQ_DEPTH);
  localparam int NW = drre_pkg::OUTQ_CNT_W;

  drre_pkg::out_word_t entry_q [drre_pkg::OUTQ_DEPTH];
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [NW-1:0] count_q, count_d;
  logic          pop;
  logic [PW-1:0] tail_next;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_word_o  = entry_q[head_q];
  assign count_o     = count_q;
  assign tail_next   = tail_q + PW'(1);

  // Advance pointers and count
  always_comb begin
    head_d  = pop ? head_q + PW'(1) : head_q;
    tail_d  = tail_q;
    count_d = count_q - NW'(pop);
    if (push_i.push_two) begin
      tail_d  = tail_q + PW'(2);
      count_d = count_d + NW'(2);
    end else if (push_i.push_one) begin
      tail_d  = tail_next;
      count_d = count_d + NW'(1);
    end
  end

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i.push_one || push_i.push_two) begin
      entry_q[tail_q] <= push_i.word0;
    end
    if (push_i.push_two) begin
      entry_q[tail_next] <= push_i.word1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== hdl/dirty_cell_run_rectangle_emitter.sv =====
// Top level of the dirty-cell run rectangle emitter.
//
//   channel  | direction | handshake             | word
//   in       | input     | in_valid_i/in_ready_o | in_word_i  (load or scan)
//   out      | output    | out_valid_o/out_ready_i | out_word_o (one rectangle)
//   cfg      | input     | cfg_we_i, no wait     | cfg_idx_i, cfg_wdata_i
//
// A scan reads both frames from the bitmap RAM at its accept edge, and its
// rectangles are pushed into the result queue in the cycle after. A scan
// yields up to two rectangles and the queue drains one per cycle while
// out_ready_i is high, so in_ready_o drops while the queue and the scan
// in flight could overfill it. After reset a clearing pass zeroes every
// bitmap byte with in_ready_o low; configuration writes are taken throughout.
module dirty_cell_run_rectangle_emitter #(
  parameter int GRID_WIDTH  = drre_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = drre_pkg::GRID_HEIGHT_DEF,
  parameter int STORE_BYTES = drre_pkg::STORE_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  drre_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output drre_pkg::out_word_t               out_word_o,
  input  logic                              cfg_we_i,
  input  logic [drre_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [drre_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int AW    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int COL_W = $clog2(GRID_WIDTH);
  localparam int ROW_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int SUM_W = $clog2(GRID_WIDTH * GRID_HEIGHT) + AW + 2;
  localparam int NW    = drre_pkg::OUTQ_CNT_W;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(STORE_BYTES / 2);
  localparam logic [SUM_W-1:0] STORE_END = SUM_W'(STORE_BYTES);

  drre_pkg::cfg_t       cfg_q, cfg_d;
  drre_pkg::scan_job_t  job_q, job_d;
  drre_pkg::rect_push_t push;

  logic             clr_q, clr_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic             accept, scan_acc, load_ok;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata, rdata_a, rdata_b;
  logic [SUM_W-1:0] cell_idx, byte_idx, addr_a, addr_b;
  logic [NW-1:0]    q_count;
  logic [NW:0]      q_need;
  logic             last_col;

  // Accept while the queue can take two more rectangles beyond the scan in flight
  assign q_need     = {1'b0, q_count} + (job_q.valid ? (NW + 1)'(2) : (NW + 1)'(0));
  assign in_ready_o = !clr_q && (q_need <= (NW + 1)'(drre_pkg::OUTQ_DEPTH - 2));
  assign accept     = in_valid_i && in_ready_o;
  assign scan_acc   = accept && (in_word_i.opcode == drre_pkg::OP_SCAN);
  assign load_ok    = accept && (in_word_i.opcode == drre_pkg::OP_LOAD)
                      && ({1'b0, in_word_i.byte_address} < 10'(STORE_BYTES));

  // Form both frame addresses of the cursor cell
  assign cell_idx = SUM_W'(row_q) * SUM_W'(GRID_WIDTH) + SUM_W'(col_q);
  assign byte_idx = cell_idx >> 2;
  assign addr_a   = (in_word_i.frame_select ? HALF : '0) + byte_idx;
  assign addr_b   = (in_word_i.frame_select ? '0 : HALF) + byte_idx;
  assign last_col = (col_q == COL_W'(GRID_WIDTH - 1));

  // Share the write port between the clearing pass and loads
  assign ram_we    = clr_q || load_ok;
  assign ram_waddr = clr_q ? clr_addr_q : in_word_i.byte_address[AW-1:0];
  assign ram_wdata = clr_q ? 8'd0 : in_word_i.byte_value;

  // Sweep the bitmap after reset
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(STORE_BYTES - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  // Advance the cursor and launch the scan into the run stage
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (scan_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = (row_q == ROW_W'(GRID_HEIGHT - 1)) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
    job_d.valid    = scan_acc;
    job_d.col      = drre_pkg::COL_MAX_W'(col_q);
    job_d.row      = drre_pkg::ROW_MAX_W'(row_q);
    job_d.lane     = cell_idx[1:0];
    job_d.a_ok     = addr_a < STORE_END;
    job_d.b_ok     = addr_b < STORE_END;
    job_d.last_col = last_col;
  end

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        drre_pkg::REG_BACKGROUND_COLOUR: cfg_d.background_colour = cfg_wdata_i;
        drre_pkg::REG_FULL_REPAINT:      cfg_d.full_repaint      = cfg_wdata_i[0];
        drre_pkg::REG_CELL_SIZE:         cfg_d.cell_size         = cfg_wdata_i[4:0];
        drre_pkg::REG_INK_CODE:          cfg_d.ink_code          = cfg_wdata_i[1:0];
        drre_pkg::REG_LIT_CODE:          cfg_d.lit_code          = cfg_wdata_i[1:0];
        drre_pkg::REG_INK_COLOUR:        cfg_d.ink_colour        = cfg_wdata_i;
        drre_pkg::REG_LIT_COLOUR:        cfg_d.lit_colour        = cfg_wdata_i;
        default:                         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.background_colour <= 16'h0000;
      cfg_q.full_repaint      <= 1'b1;
      cfg_q.cell_size         <= 5'd8;
      cfg_q.ink_code          <= 2'd1;
      cfg_q.lit_code          <= 2'd2;
      cfg_q.ink_colour        <= 16'h0000;
      cfg_q.lit_colour        <= 16'hFFFF;
      clr_q                   <= 1'b1;
      clr_addr_q              <= '0;
      col_q                   <= '0;
      row_q                   <= '0;
      job_q                   <= '0;
    end else begin
      cfg_q      <= cfg_d;
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      col_q      <= col_d;
      row_q      <= row_d;
      job_q      <= job_d;
    end
  end

  drre_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_bitmap (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (addr_a[AW-1:0]),
    .raddr_b_i (addr_b[AW-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  drre_run #(
    .GRID_WIDTH (GRID_WIDTH)
  ) u_run (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (job_q),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .cfg_i     (cfg_q),
    .push_o    (push)
  );

  drre_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .count_o     (q_count)
  );

endmodule

// ===== hdl/drre_checker.sv =====
// Port-level checks of the emitter and their attachment to the top level.
module drre_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input drre_pkg::out_word_t             out_word_o
);

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // The clearing pass keeps the input closed right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input open during clearing pass");

  // Rectangle height is a clamped cell edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.rect_height != 5'd0) && (out_word_o.rect_height <= 5'd16))
    else $error("rectangle height out of range");

  // Every run covers at least one cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.rect_width != 10'd0))
    else $error("empty rectangle emitted");

endmodule

bind dirty_cell_run_rectangle_emitter drre_checker u_drre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
